// File: hdl/spq_pkg.sv
package spq_pkg;

    // Number of cells in the queue.
    localparam int DEPTH = 16;
    // Width of the internal fill count, wide enough to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int PRI_W   = 16;
    localparam int TAG_W   = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // One queue entry.
    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic do_put;   // place a new entry somewhere in the row
        logic by_key;   // position chosen by priority (sorted insert)
        logic do_pop;   // shift the whole row one place toward the front
    } cell_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  logic       occupied,
    input  logic       found_in,
    output logic       found_out,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   here;

    // This cell is the insertion point candidate when it is free, or, for a
    // sorted insert, when it holds a strictly higher priority key.
    assign here      = !occupied || (ctrl.by_key && (entry_reg.pri > new_entry.pri));
    assign found_out = found_in || here;
    assign entry     = entry_reg;

    // Next contents: shift back behind the insertion point, take the new
    // entry at it, or shift forward on a dequeue.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_put)
        begin
            if (found_in)
            begin
                entry_next = left_entry;
            end
            else if (here)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.do_pop)
        begin
            entry_next = right_entry;
        end
    end

    // Entry storage carries no reset; occupancy is tracked by the count.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: hdl/stable_priority_queue_core.sv
// Stable priority queue core.
// Request channel: req_valid/req_stall carry one operation per beat with
// opcode, priority_req and payload. Opcodes are sorted insert (placed after
// every entry of lower or equal priority), append at back, dequeue front and
// peek front.
// Response channel: rsp_valid/rsp_stall carry exactly one result beat per
// request, with status, out_priority, out_payload and the count held after
// the operation. Results leave in request order.
// A request's result is registered and shows from the cycle after it is
// accepted. Throughput is one operation per cycle unless req_stall holds it;
// every cell updates in the same cycle, so the DEPTH cells set no limit.
// The output register decouples the sides: while a result waits, a new
// request is stalled only if the receiver is stalling too.
// Reset (rst_n, asynchronous, active low) empties the queue and drops any
// pending result. Cell contents are not cleared; only cells below the count
// are ever read.
// Full inserts report status full and drop the entry; dequeue or peek on an
// empty queue reports status empty with zero data.
module stable_priority_queue_core
    import spq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [OP_W-1:0]    opcode,
    input  logic [PRI_W-1:0]   priority_req,
    input  logic [TAG_W-1:0]   payload,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [STAT_W-1:0]  status,
    output logic [PRI_W-1:0]   out_priority,
    output logic [TAG_W-1:0]   out_payload,
    output logic [COUNT_W-1:0] count
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    entry_t                   out_entry_reg;
    entry_t                   out_entry_next;
    logic [COUNT_W-1:0]       count_out_reg;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    entry_t                   new_entry;
    entry_t                   cell_entry [DEPTH];
    logic                     found      [DEPTH+1];

    // A new request waits only while a result is held and the receiver stalls.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_entry.pri = priority_req;
    assign new_entry.tag = payload;

    // Decode the operation into the cell command, status and next count.
    always_comb
    begin
        ctrl           = '0;
        status_next    = ST_OK;
        out_entry_next = '0;
        count_next     = count_reg;
        unique case (opcode)
            OP_INSERT, OP_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.do_put = accept;
                    ctrl.by_key = (opcode == OP_INSERT);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    out_entry_next = cell_entry[0];
                    if (opcode == OP_DEQUEUE)
                    begin
                        ctrl.do_pop = accept;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Row of cells; the insertion-point flag ripples from front to back.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_front
            assign left_entry = new_entry;
        end
        else
        begin : g_mid_l
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid_r
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (CNT_W'(i) < count_reg),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .entry       (cell_entry[i])
        );
    end

    // Response valid holds until the receiver takes the beat.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Low bits of the count after the operation.
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            count_out_reg <= count_ext[COUNT_W-1:0];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_priority = out_entry_reg.pri;
    assign out_payload  = out_entry_reg.tag;
    assign count        = count_out_reg;

endmodule

// File: hdl/spq_checker.sv
module spq_checker
    import spq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [OP_W-1:0]    opcode,
    input logic [PRI_W-1:0]   priority_req,
    input logic [TAG_W-1:0]   payload,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [STAT_W-1:0]  status,
    input logic [PRI_W-1:0]   out_priority,
    input logic [TAG_W-1:0]   out_payload,
    input logic [COUNT_W-1:0] count
);

    localparam logic [CNT_W+COUNT_W-1:0] DEPTH_EXT = (CNT_W + COUNT_W)'(DEPTH);

    // A pending result is not withdrawn while the receiver stalls.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response beat dropped while stalled");

    // Requests are held back only behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled without a stalled response");

    // Every accepted request yields a result beat in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request produced no response");

    // An empty report carries zero data and a zero count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |->
            (count == '0) && (out_priority == '0) && (out_payload == '0))
        else $error("empty status with data or nonzero count");

    // A full report shows the queue holding every cell.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |->
            (count == DEPTH_EXT[COUNT_W-1:0]) && (out_priority == '0))
        else $error("full status with wrong count or data");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (.*);
